// ===== rtl/core/arm_forward_kinematics_defines.svh =====
// Assertion macros shared by the arm forward kinematics RTL.
`ifndef ARM_FORWARD_KINEMATICS_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/afk_pkg.sv =====
// Package: formats, constants and helpers of the arm forward kinematics block.
`default_nettype none
package afk_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	localparam int ZW = 34;
	localparam int XW = 33;

	localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] PI_HALF_Q30 = 34'sd1686629713;

	localparam logic signed [ZW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
		34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
		34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
		34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
		34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
		34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
		34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
	};

	localparam logic [7:0] REG_BASE_OFFSET = 8'd0;
	localparam logic [7:0] REG_UPPER_LINK = 8'd1;
	localparam logic [7:0] REG_LOWER_LINK = 8'd2;
	localparam logic [7:0] REG_TOOL_LENGTH = 8'd3;

	typedef struct packed {
		logic [15:0] base_offset;
		logic [15:0] upper_link;
		logic [15:0] lower_link;
		logic [15:0] tool_length;
	} cfg_t;

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		logic signed [23:0] r;
		if (v > 27'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -27'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/afk_cordic.sv =====
// Pipelined CORDIC: quadrant fold, one rotation per stage, sign restore.
`default_nettype none
module afk_cordic (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [15:0]            angle,
	output logic                               out_valid,
	output logic signed [afk_pkg::XW-1:0]      cos_q,
	output logic signed [afk_pkg::XW-1:0]      sin_q
);

	logic signed [afk_pkg::XW-1:0] x_s [0:afk_pkg::STEPS];
	logic signed [afk_pkg::XW-1:0] y_s [0:afk_pkg::STEPS];
	logic signed [afk_pkg::ZW-1:0] z_s [0:afk_pkg::STEPS];
	logic                          f_s [0:afk_pkg::STEPS];
	logic                          v_s [0:afk_pkg::STEPS];

	logic signed [afk_pkg::ZW-1:0] z_in;
	assign z_in = {angle[15], angle, 17'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= afk_pkg::GAIN_Q30;
			y_s[0] <= '0;
			if (z_in > afk_pkg::PI_HALF_Q30) begin
				z_s[0] <= z_in - afk_pkg::PI_Q30;
				f_s[0] <= 1'b1;
			end else if (z_in < -afk_pkg::PI_HALF_Q30) begin
				z_s[0] <= z_in + afk_pkg::PI_Q30;
				f_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z_in;
				f_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < afk_pkg::STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (!z_s[i][afk_pkg::ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - afk_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + afk_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[afk_pkg::STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= f_s[afk_pkg::STEPS] ? -x_s[afk_pkg::STEPS] : x_s[afk_pkg::STEPS];
			sin_q <= f_s[afk_pkg::STEPS] ? -y_s[afk_pkg::STEPS] : y_s[afk_pkg::STEPS];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/afk_math.sv =====
// Link products, reach and position arithmetic with rounding and saturation.
`default_nettype none
module afk_math (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire afk_pkg::cfg_t                 cfg,
	input  wire logic                          in_valid,
	input  wire logic signed [afk_pkg::XW-1:0] c0,
	input  wire logic signed [afk_pkg::XW-1:0] s0,
	input  wire logic signed [afk_pkg::XW-1:0] c1,
	input  wire logic signed [afk_pkg::XW-1:0] s1,
	input  wire logic signed [afk_pkg::XW-1:0] c2,
	input  wire logic signed [afk_pkg::XW-1:0] s2,
	output logic                               out_valid,
	output logic signed [23:0]                 pos_x,
	output logic signed [23:0]                 pos_y,
	output logic signed [23:0]                 pos_z
);

	logic signed [16:0] l2;
	logic signed [17:0] l3;
	assign l2 = $signed({1'b0, cfg.upper_link});
	assign l3 = $signed({2'b00, cfg.lower_link} + {2'b00, cfg.tool_length});

	// stage 1: link products
	logic                v_s1;
	logic signed [50:0]  ma_s1, mb_s1, mc_s1, md_s1;
	logic signed [afk_pkg::XW-1:0] c0_s1, s0_s1;

	// stage 2: reach and z
	logic                v_s2;
	logic signed [30:0]  reach_s2;
	logic signed [23:0]  pz_s2;
	logic signed [afk_pkg::XW-1:0] c0_s2, s0_s2;

	// stage 3: planar products
	logic                v_s3;
	logic signed [63:0]  px_s3, py_s3;
	logic signed [23:0]  pz_s3;

	logic signed [52:0] reach_full;
	logic signed [52:0] pz_full;
	logic signed [30:0] reach_rnd;
	logic signed [22:0] pz_rnd;
	logic signed [64:0] nx, ny;
	logic signed [26:0] rx, ry;

	assign reach_full = 53'(ma_s1) + 53'(mb_s1)
		+ $signed({3'b000, cfg.base_offset, 34'd0} >> 4) + 53'sd2097152;
	assign reach_rnd = 31'(reach_full >>> 22);
	assign pz_full = 53'(mc_s1) - 53'(md_s1) + 53'sd536870912;
	assign pz_rnd = 23'(pz_full >>> 30);

	assign nx = -65'(px_s3) + 65'sh2000000000;
	assign ny = -65'(py_s3) + 65'sh2000000000;
	assign rx = 27'(nx >>> 38);
	assign ry = 27'(ny >>> 38);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= 51'(l2 * s1);
			mb_s1 <= 51'(l3 * c2);
			mc_s1 <= 51'(l2 * c1);
			md_s1 <= 51'(l3 * s2);
			c0_s1 <= c0;
			s0_s1 <= s0;

			reach_s2 <= reach_rnd;
			pz_s2 <= 24'(pz_rnd);
			c0_s2 <= c0_s1;
			s0_s2 <= s0_s1;

			px_s3 <= 64'(reach_s2 * c0_s2);
			py_s3 <= 64'(reach_s2 * s0_s2);
			pz_s3 <= pz_s2;

			pos_x <= afk_pkg::sat24(rx);
			pos_y <= afk_pkg::sat24(ry);
			pos_z <= pz_s3;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/arm_forward_kinematics.sv =====
// Top level: arm forward kinematics, angle triple in, end-effector position out.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_ready  | angle_base, angle_upper, angle_lower
//   output   | out_valid / out_ready| pos_x, pos_y, pos_z
//   config   | cfg_we               | cfg_index, cfg_data
//
// One request per cycle while in_ready is high; each request passes through the fold,
// rotations, sign restore and four arithmetic stages.
// Reset clears the link registers and all valid bits.
// The whole pipeline holds while a result waits and out_ready is low.
`default_nettype none
`include "arm_forward_kinematics_defines.svh"
module arm_forward_kinematics (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] angle_base,
	input  wire logic signed [15:0] angle_upper,
	input  wire logic signed [15:0] angle_lower,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      pos_x,
	output logic signed [23:0]      pos_y,
	output logic signed [23:0]      pos_z,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	afk_pkg::cfg_t cfg_q;
	logic en;
	logic v0, v1, v2;
	logic signed [afk_pkg::XW-1:0] c0, s0, c1, s1, c2, s2;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				afk_pkg::REG_BASE_OFFSET: cfg_q.base_offset <= cfg_data;
				afk_pkg::REG_UPPER_LINK:  cfg_q.upper_link <= cfg_data;
				afk_pkg::REG_LOWER_LINK:  cfg_q.lower_link <= cfg_data;
				afk_pkg::REG_TOOL_LENGTH: cfg_q.tool_length <= cfg_data;
				default: ;
			endcase
		end
	end

	afk_cordic u_cordic_base (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.angle(angle_base), .out_valid(v0), .cos_q(c0), .sin_q(s0)
	);

	afk_cordic u_cordic_upper (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.angle(angle_upper), .out_valid(v1), .cos_q(c1), .sin_q(s1)
	);

	afk_cordic u_cordic_lower (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.angle(angle_lower), .out_valid(v2), .cos_q(c2), .sin_q(s2)
	);

	afk_math u_math (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q), .in_valid(v0),
		.c0(c0), .s0(s0), .c1(c1), .s1(s1), .c2(c2), .s2(s2),
		.out_valid(out_valid), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
	);

	`AFK_ASSERT_NOW(a_lanes_agree, 1'b1, (v0 == v1) && (v1 == v2), "CORDIC lanes out of step")
	`AFK_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(pos_z), "result changed under stall")
	`AFK_ASSERT_NEXT(a_bad_index, cfg_we && (cfg_index > afk_pkg::REG_TOOL_LENGTH), $stable(cfg_q), "write beyond register list took effect")

endmodule
`default_nettype wire

// ===== dv/tb_arm_forward_kinematics.sv =====
// Testbench for arm_forward_kinematics: random and corner angle triples under several
// link settings and handshake stall patterns, checked against a fixed-point CORDIC predictor.
`default_nettype none
module tb_arm_forward_kinematics;

	typedef struct {
		logic signed [15:0] a0;
		logic signed [15:0] a1;
		logic signed [15:0] a2;
	} angles_t;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} position_t;

	logic clk, arst_n;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid;
	logic signed [15:0] angle_base = 16'sd0;
	logic signed [15:0] angle_upper = 16'sd0;
	logic signed [15:0] angle_lower = 16'sd0;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic cfg_we;
	logic [7:0] cfg_index;
	logic [15:0] cfg_data;

	arm_forward_kinematics uut (.*);

	angles_t pending_angles[$];
	position_t expected_positions[$];
	longint len_base, len_upper, len_lower, len_tool;
	int send_idle_pct, recv_stall_pct;
	bit hold_requests;
	int mismatches, results_seen, requests_sent, phases_run;

	function automatic void cordic_sincos(input logic signed [15:0] a,
			output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(a) * 131072;
		flip = 0;
		x = 652032874;
		y = 0;
		if (z > longint'(afk_pkg::PI_HALF_Q30)) begin
			z -= longint'(afk_pkg::PI_Q30);
			flip = 1;
		end else if (z < -longint'(afk_pkg::PI_HALF_Q30)) begin
			z += longint'(afk_pkg::PI_Q30);
			flip = 1;
		end
		for (int i = 0; i < afk_pkg::STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(afk_pkg::ATAN_TAB[i]);
			end else begin
				x += dx;
				y -= dy;
				z += longint'(afk_pkg::ATAN_TAB[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint round_half_up(input longint v, input int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [23:0] clamp24(input longint v);
		if (v > 8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic position_t predict_position(input angles_t a);
		longint c0, s0, c1, s1, c2, s2, l3, reach;
		position_t p;
		cordic_sincos(a.a0, c0, s0);
		cordic_sincos(a.a1, c1, s1);
		cordic_sincos(a.a2, c2, s2);
		l3 = len_lower + len_tool;
		reach = len_upper * s1 + l3 * c2 + len_base * (longint'(1) << 30);
		reach = round_half_up(reach, 22);
		p.x = clamp24(round_half_up(-(reach * c0), 38));
		p.y = clamp24(round_half_up(-(reach * s0), 38));
		p.z = clamp24(round_half_up(len_upper * c1 - l3 * s2, 30));
		return p;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		angles_t a;
		bit busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				a.a0 = angle_base;
				a.a1 = angle_upper;
				a.a2 = angle_lower;
				expected_positions = {expected_positions, predict_position(a)};
				requests_sent++;
				busy = 0;
			end
			if (!busy) begin
				if (pending_angles.size() > 0 && !hold_requests &&
						$urandom_range(99) >= send_idle_pct) begin
					a = pending_angles.pop_front();
					angle_base <= a.a0;
					angle_upper <= a.a1;
					angle_lower <= a.a2;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		position_t e;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_positions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
				end else begin
					e = expected_positions.pop_front();
					if (e.x !== pos_x || e.y !== pos_y || e.z !== pos_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
								e.x, e.y, e.z, pos_x, pos_y, pos_z);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			afk_pkg::REG_BASE_OFFSET: len_base = longint'(val);
			afk_pkg::REG_UPPER_LINK: len_upper = longint'(val);
			afk_pkg::REG_LOWER_LINK: len_lower = longint'(val);
			afk_pkg::REG_TOOL_LENGTH: len_tool = longint'(val);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic wait_drained();
		while (pending_angles.size() > 0 || in_valid || expected_positions.size() > 0)
			@(posedge clk);
		repeat (afk_pkg::CORDIC_STEPS + 14) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(9))
			0: return 16'(25736 - $urandom_range(40));
			1: return 16'(-25736 + $urandom_range(40));
			2: return 16'(12868 - $urandom_range(3));
			3: return 16'(-12868 + $urandom_range(3));
			default: return 16'($signed($urandom_range(51472)) - 25736);
		endcase
	endfunction

	task automatic push_angles(input int a0, input int a1, input int a2);
		angles_t a;
		a.a0 = 16'(a0);
		a.a1 = 16'(a1);
		a.a2 = 16'(a2);
		pending_angles = {pending_angles, a};
	endtask

	initial begin
		int corner[8];
		corner = '{0, 25736, -25736, 12867, 12868, -12867, -12868, 6434};
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		len_base = 0;
		len_upper = 0;
		len_lower = 0;
		len_tool = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		phases_run = 0;
		repeat (11) @(posedge clk);
		arst_n <= 0;
		@(negedge clk);
		arst_n = 1;

		// all lengths zero after reset
		push_angles(1000, -2000, 3000);
		push_angles(25736, 25736, 25736);
		wait_drained();
		write_reg(afk_pkg::REG_BASE_OFFSET, 16'hFFFF);
		write_reg(afk_pkg::REG_UPPER_LINK, 16'hFFFF);
		write_reg(afk_pkg::REG_LOWER_LINK, 16'hFFFF);
		write_reg(afk_pkg::REG_TOOL_LENGTH, 16'hFFFF);
		// out-of-range indexes must leave the lengths alone
		write_reg(8'd4, 16'h1234);
		write_reg(8'd255, 16'h0001);
		for (int i = 0; i < 8; i++)
			push_angles(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
		push_angles(-25736, -25736, -25736);
		push_angles(25736, -25736, 0);
		push_angles(0, 0, 0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 67; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 67; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			case (ph)
				0: begin
					write_reg(afk_pkg::REG_BASE_OFFSET, 16'd0);
					write_reg(afk_pkg::REG_UPPER_LINK, 16'd0);
					write_reg(afk_pkg::REG_LOWER_LINK, 16'd0);
					write_reg(afk_pkg::REG_TOOL_LENGTH, 16'd0);
				end
				1: begin
					write_reg(afk_pkg::REG_BASE_OFFSET, 16'hFFFF);
					write_reg(afk_pkg::REG_UPPER_LINK, 16'hFFFF);
					write_reg(afk_pkg::REG_LOWER_LINK, 16'hFFFF);
					write_reg(afk_pkg::REG_TOOL_LENGTH, 16'hFFFF);
				end
				2: begin
					write_reg(afk_pkg::REG_BASE_OFFSET, 16'd0);
					write_reg(afk_pkg::REG_TOOL_LENGTH, 16'hFFFF);
				end
				default: begin
					write_reg(afk_pkg::REG_BASE_OFFSET, 16'($urandom));
					write_reg(afk_pkg::REG_UPPER_LINK, 16'($urandom));
					write_reg(afk_pkg::REG_LOWER_LINK, 16'($urandom));
					write_reg(afk_pkg::REG_TOOL_LENGTH, 16'($urandom));
				end
			endcase
			for (int n = 0; n < 235; n++)
				push_angles(rand_angle(), rand_angle(), rand_angle());
			if (ph == 3) begin
				while (pending_angles.size() > 120)
					@(posedge clk);
				hold_requests = 1;
				while (in_valid || expected_positions.size() > 0)
					@(posedge clk);
				hold_requests = 0;
			end
			wait_drained();
			phases_run++;
		end

		$display("covered %0d requests, %0d results over %0d length settings",
			requests_sent, results_seen, phases_run + 2);
		$display("stall mixes: none, sender, receiver, both; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
